FILE: hw/rtl/deque_with_key_delete_top_defines.svh
// assertion macros for the deque with key delete
// used by deque_with_key_delete_top, no other dependencies
`ifndef DEQUE_WITH_KEY_DELETE_TOP_DEFINES_SVH
`define DEQUE_WITH_KEY_DELETE_TOP_DEFINES_SVH

// same-cycle implication
`define DWKD_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dwkd assertion failed");

// next-cycle implication
`define DWKD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dwkd assertion failed");

`endif

FILE: hw/rtl/dwkd_pkg.sv
// shared types and codes for the deque with key delete
// no dependencies
package dwkd_pkg;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd5;
   localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_PREV,
      CELL_NEXT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        occupied;
      logic        is_back;
   } cell_ctrl_type;

endpackage

FILE: hw/rtl/dwkd_if.sv
// request and response channel interfaces for the deque with key delete
// depends on dwkd_pkg
interface dwkd_req_if import dwkd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink (input valid, input cmd, input value, output ready);
endinterface

interface dwkd_rsp_if import dwkd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                found;
   logic [VALUE_W-1:0]  front_value;
   logic [VALUE_W-1:0]  back_value;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, output status, output found, output front_value,
                   output back_value, output count, input ready);
   modport sink (input valid, input status, input found, input front_value,
                 input back_value, input count, output ready);
endinterface

FILE: hw/rtl/deque_with_key_delete_top.sv
// deque with key delete: the result is valid in the cycle after
// the accepting edge; a new item is taken in the same cycle the pending result is taken.
// throughput one item per cycle while results are taken, set by the compare and shift in the cells.
// reset clears the entry count and the result valid; entry contents stay undefined.
// depends on dwkd_pkg, dwkd_if, dwkd_cell and deque_with_key_delete_top_defines.svh
`include "deque_with_key_delete_top_defines.svh"
module deque_with_key_delete_top
   import dwkd_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   dwkd_req_if.sink   req_item,
   dwkd_rsp_if.source rsp_item
);

   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int VW    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int LOG_D = $clog2(DEPTH);

   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  found_ff, found_in;

   logic                  accept;
   logic                  full, empty, any_match;
   logic                  is_push;
   logic [DATA_WIDTH-1:0] key;
   logic [DEPTH-1:0]      match;
   logic [DEPTH-1:0]      pfx;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DATA_WIDTH-1:0] back_tap [DEPTH];
   logic [DATA_WIDTH-1:0] back_or;
   cell_ctrl_type         ctrl [DEPTH];

   logic                  do_push_front, do_push_back, do_pop_front, do_delete;

   assign accept   = req_item.valid && req_item.ready;
   assign req_item.ready = !rsp_valid_ff || rsp_item.ready;
   assign key      = DATA_WIDTH'(req_item.value[VW-1:0]);
   assign full     = (occ_ff == OCC_W'(DEPTH));
   assign empty    = (occ_ff == '0);
   assign any_match = |match;
   assign is_push  = (req_item.cmd == CMD_PUSH_FRONT) || (req_item.cmd == CMD_PUSH_BACK);

   // first match and every cell behind it
   always_comb begin
      pfx = match;
      for (int k = 0; k < LOG_D; k++) begin
         pfx = pfx | (pfx << (1 << k));
      end
   end

   always_comb begin
      status_in     = ST_OK;
      found_in      = 1'b0;
      occ_in        = occ_ff;
      do_push_front = 1'b0;
      do_push_back  = 1'b0;
      do_pop_front  = 1'b0;
      do_delete     = 1'b0;
      case (req_item.cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               occ_in        = occ_ff + 1'b1;
               do_push_front = (req_item.cmd == CMD_PUSH_FRONT);
               do_push_back  = (req_item.cmd == CMD_PUSH_BACK);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               occ_in       = occ_ff - 1'b1;
               do_pop_front = (req_item.cmd == CMD_POP_FRONT);
            end
         end
         CMD_CONTAINS: begin
            found_in = any_match;
         end
         CMD_DELETE: begin
            found_in = any_match;
            if (any_match) begin
               occ_in    = occ_ff - 1'b1;
               do_delete = 1'b1;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
      if (!accept) begin
         occ_in = occ_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ctrl[i].occupied = (OCC_W'(i) < occ_ff);
         ctrl[i].is_back  = (OCC_W'(i + 1) == occ_ff);
         ctrl[i].op       = CELL_HOLD;
         if (accept) begin
            if (do_push_front) begin
               ctrl[i].op = (i == 0) ? CELL_LOAD : CELL_PREV;
            end else if (do_push_back && (OCC_W'(i) == occ_ff)) begin
               ctrl[i].op = CELL_LOAD;
            end else if (do_pop_front || (do_delete && pfx[i])) begin
               ctrl[i].op = CELL_NEXT;
            end
         end
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_data;
      logic [DATA_WIDTH-1:0] next_data;
      if (i == 0) begin : g_first
         assign prev_data = cell_data[i];
      end else begin : g_mid_prev
         assign prev_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_data = cell_data[i];
      end else begin : g_mid_next
         assign next_data = cell_data[i+1];
      end
      dwkd_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl[i]),
         .key       (key),
         .prev_data (prev_data),
         .next_data (next_data),
         .data      (cell_data[i]),
         .match     (match[i]),
         .back_tap  (back_tap[i])
      );
   end

   always_comb begin
      back_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_or = back_or | back_tap[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_item.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   assign rsp_item.valid       = rsp_valid_ff;
   assign rsp_item.status      = status_ff;
   assign rsp_item.found       = found_ff;
   assign rsp_item.count       = COUNT_W'(occ_ff);
   assign rsp_item.front_value = empty ? '0 : VALUE_W'(cell_data[0][VW-1:0]);
   assign rsp_item.back_value  = VALUE_W'(back_or[VW-1:0]);

   `DWKD_ASSERT_NOW(occ_bounded, clock, reset, 1'b1, occ_ff <= OCC_W'(DEPTH))
   `DWKD_ASSERT_NEXT(push_grows, clock, reset, accept && !full && is_push, occ_ff == OCC_W'($past(occ_ff) + 1'b1))
   `DWKD_ASSERT_NEXT(delete_hit, clock, reset, accept && any_match && req_item.cmd == CMD_DELETE, rsp_item.valid && found_ff && status_ff == ST_OK)

endmodule

FILE: hw/rtl/dwkd_cell.sv
// one storage cell of the deque chain: holds an entry, compares the key
// depends on dwkd_pkg
module dwkd_cell
   import dwkd_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] key,
   input  logic [DATA_WIDTH-1:0] prev_data,
   input  logic [DATA_WIDTH-1:0] next_data,
   output logic [DATA_WIDTH-1:0] data,
   output logic                  match,
   output logic [DATA_WIDTH-1:0] back_tap
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      case (ctrl.op)
         CELL_LOAD: data_in = key;
         CELL_PREV: data_in = prev_data;
         CELL_NEXT: data_in = next_data;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign match    = ctrl.occupied && (data_ff == key);
   assign back_tap = ctrl.is_back ? data_ff : '0;

endmodule
